// ===== hw/rtl/recent_screen_mru_list_defines.svh =====
// ----------------------------------------------------------------------------
// Recent screen list assertion macros
// Shared concurrent assertion forms, sampled on i_clk, muted during reset.
// ----------------------------------------------------------------------------
`ifndef RECENT_SCREEN_MRU_LIST_DEFINES_SVH
`define RECENT_SCREEN_MRU_LIST_DEFINES_SVH

// Plain property check.
`define RSML_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle implication check.
`define RSML_ASSERT_IMPL(lbl, ante, cons, msg) \
    `RSML_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/rsml_pkg.sv =====
// ----------------------------------------------------------------------------
// rsml_pkg
// Types and fixed constants shared by the recent screen list modules.
// ----------------------------------------------------------------------------
package rsml_pkg;

    localparam int KIND_W    = 2;
    localparam int SCREEN_W  = 6;
    localparam int POS_W     = 8;
    localparam int COUNT_W   = 4;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECORD = 2'd0,
        KIND_READ   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // latch a new item
        logic rd_capture;  // capture read result and hit
        logic set_hit;
        logic clear_used;
        logic ptr_inc;
        logic ptr_top;     // point at the insertion top
        logic up_step;     // entry[ptr] <= entry[ptr-1], ptr--
        logic dn_step;     // entry[ptr] <= entry[ptr+1], ptr++
        logic front_wr;    // entry[0] <= screen
        logic used_inc;
        logic used_dec;
        logic out_load;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_kind kind;
        logic  mask_ok;
        logic  in_range;
        logic  match;
        logic  last;
        logic  dn_more;
        logic  ptr_zero;
        logic  room;
        logic  empty;
        logic  hit;
        logic  out_free;
    } t_stat;

endpackage

// ===== hw/rtl/rsml_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsml_ctrl
// Sequencer for the recent screen list: decode, search, shift, finish.
// ----------------------------------------------------------------------------
module rsml_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rsml_pkg::t_stat i_stat,
    output rsml_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DECODE   = 6'b000010,
        S_SEARCH   = 6'b000100,
        S_SHIFT_UP = 6'b001000,
        S_SHIFT_DN = 6'b010000,
        S_FINISH   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.kind)
                    rsml_pkg::KIND_RECORD: begin
                        if (!i_stat.mask_ok) begin
                            n_state = S_FINISH;
                        end else if (i_stat.empty) begin
                            o_cmd.ptr_top = 1'b1;
                            n_state       = S_SHIFT_UP;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end
                    rsml_pkg::KIND_READ: begin
                        o_cmd.rd_capture = 1'b1;
                        n_state          = S_FINISH;
                    end
                    rsml_pkg::KIND_REMOVE: begin
                        if (i_stat.in_range) begin
                            o_cmd.set_hit = 1'b1;
                            n_state       = S_SHIFT_DN;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    rsml_pkg::KIND_CLEAR: begin
                        o_cmd.clear_used = 1'b1;
                        n_state          = S_FINISH;
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_SEARCH: begin
                if (i_stat.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = i_stat.ptr_zero ? S_FINISH : S_SHIFT_UP;
                end else if (i_stat.last) begin
                    o_cmd.ptr_top = 1'b1;
                    n_state       = S_SHIFT_UP;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_SHIFT_UP: begin
                if (i_stat.ptr_zero) begin
                    o_cmd.front_wr = 1'b1;
                    o_cmd.used_inc = !i_stat.hit && i_stat.room;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.up_step = 1'b1;
                end
            end
            S_SHIFT_DN: begin
                if (i_stat.dn_more) begin
                    o_cmd.dn_step = 1'b1;
                end else begin
                    o_cmd.used_dec = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/rsml_dp.sv =====
// ----------------------------------------------------------------------------
// rsml_dp
// List storage, pointer, count, config registers and output register.
// ----------------------------------------------------------------------------
`include "recent_screen_mru_list_defines.svh"

module rsml_dp #(
    parameter int LIST_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rsml_pkg::t_cmd                  i_cmd,
    output rsml_pkg::t_stat                 o_stat,
    input  logic [rsml_pkg::KIND_W-1:0]     i_kind,
    input  logic [rsml_pkg::SCREEN_W-1:0]   i_screen,
    input  logic [rsml_pkg::POS_W-1:0]      i_position,
    input  logic                            i_cfg_we,
    input  logic [rsml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsml_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [rsml_pkg::SCREEN_W-1:0]   o_screen_out,
    output logic                            o_hit,
    output logic [rsml_pkg::COUNT_W-1:0]    o_count
);

    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [IW-1:0] LAST_C  = IW'(LIST_DEPTH - 1);

    logic [rsml_pkg::MASK_W-1:0]   r_mask;
    logic [rsml_pkg::SCREEN_W-1:0] r_dflt;
    rsml_pkg::t_kind               r_kind;
    logic [rsml_pkg::SCREEN_W-1:0] r_screen;
    logic [rsml_pkg::POS_W-1:0]    r_pos;
    logic [IW-1:0]                 r_ptr;
    logic [CW-1:0]                 r_used;
    logic                          r_hit;
    logic [rsml_pkg::SCREEN_W-1:0] r_scr;
    logic [rsml_pkg::SCREEN_W-1:0] r_entries [LIST_DEPTH];
    logic                          r_out_valid;
    logic [rsml_pkg::SCREEN_W-1:0] r_out_scr;
    logic                          r_out_hit;
    logic [rsml_pkg::COUNT_W-1:0]  r_out_cnt;

    logic [IW-1:0]                 rd_addr;
    logic [rsml_pkg::SCREEN_W-1:0] rd_data;
    logic [CW-1:0]                 ptr_next;
    logic                          in_range;
    logic [IW-1:0]                 top;
    logic                          wr_en;
    logic [IW-1:0]                 wr_addr;
    logic [rsml_pkg::SCREEN_W-1:0] wr_data;

    // Single read port; address follows the step in progress
    assign ptr_next = CW'(r_ptr) + CW'(1);
    assign rd_addr  = i_cmd.up_step ? (r_ptr - IW'(1)) :
                      i_cmd.dn_step ? IW'(ptr_next) : r_ptr;
    assign rd_data  = r_entries[rd_addr];

    assign in_range = r_pos < rsml_pkg::POS_W'(r_used);
    assign top      = (r_used >= DEPTH_C) ? LAST_C : IW'(r_used);

    assign wr_en   = i_cmd.up_step || i_cmd.dn_step || i_cmd.front_wr;
    assign wr_addr = i_cmd.front_wr ? '0 : r_ptr;
    assign wr_data = i_cmd.front_wr ? r_screen : rd_data;

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.mask_ok  = r_mask[r_screen];
        o_stat.in_range = in_range;
        o_stat.match    = (rd_data == r_screen);
        o_stat.last     = (ptr_next == r_used);
        o_stat.dn_more  = (ptr_next < r_used);
        o_stat.ptr_zero = (r_ptr == '0);
        o_stat.room     = (r_used < DEPTH_C);
        o_stat.empty    = (r_used == '0);
        o_stat.hit      = r_hit;
        o_stat.out_free = !r_out_valid || i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_entries[wr_addr] <= wr_data;
        end
    end

    // Item latch, pointer and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= rsml_pkg::t_kind'(i_kind);
            r_screen <= i_screen;
            r_pos    <= i_position;
            r_hit    <= 1'b0;
            r_scr    <= '0;
            r_ptr    <= (rsml_pkg::t_kind'(i_kind) == rsml_pkg::KIND_RECORD) ?
                        '0 : IW'(i_position);
        end else begin
            if (i_cmd.rd_capture) begin
                r_scr <= in_range ? rd_data : r_dflt;
                r_hit <= in_range;
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.ptr_top) begin
                r_ptr <= top;
            end else if (i_cmd.ptr_inc || i_cmd.dn_step) begin
                r_ptr <= r_ptr + IW'(1);
            end else if (i_cmd.up_step) begin
                r_ptr <= r_ptr - IW'(1);
            end
        end
        if (i_cmd.out_load) begin
            r_out_scr <= r_scr;
            r_out_hit <= r_hit;
            r_out_cnt <= rsml_pkg::COUNT_W'(r_used);
        end
    end

    // Count, output valid and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_mask      <= '1;
            r_dflt      <= '0;
        end else begin
            if (i_cmd.clear_used) begin
                r_used <= '0;
            end else if (i_cmd.used_inc) begin
                r_used <= r_used + CW'(1);
            end else if (i_cmd.used_dec) begin
                r_used <= r_used - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rsml_pkg::CFG_TASK_MASK: r_mask <= i_cfg_data;
                    rsml_pkg::CFG_DEFAULT:   r_dflt <= i_cfg_data[rsml_pkg::SCREEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_screen_out = r_out_scr;
    assign o_hit        = r_out_hit;
    assign o_count      = r_out_cnt;

    `RSML_ASSERT(a_used_bound, r_used <= DEPTH_C, "list count beyond depth")
    `RSML_ASSERT_IMPL(a_inc_room, i_cmd.used_inc, r_used < DEPTH_C, "push into full list")
    `RSML_ASSERT_IMPL(a_dec_nonempty, i_cmd.used_dec, r_used != '0, "remove from empty list")
    `RSML_ASSERT_IMPL(a_out_free, i_cmd.out_load, !r_out_valid || i_ready, "result overwritten")
    `RSML_ASSERT(a_clear, i_cmd.clear_used |=> r_used == '0, "clear left entries")

endmodule

// ===== hw/rtl/recent_screen_mru_list.sv =====
// ----------------------------------------------------------------------------
// recent_screen_mru_list
// Most-recently-used list of screen codes with move-to-front on record,
// indexed read and remove, and clear. One result beat per item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ---------------------------------------
//  item in   i_valid / o_ready      i_kind, i_screen, i_position
//  result    o_valid / i_ready      o_screen_out, o_hit, o_count
//  config    i_cfg_we               i_cfg_idx, i_cfg_data (no wait)
//
//  Sequence: read, clear, masked record and out-of-range remove go from decode straight
//  to finish; a remove closes up the entries after the removed one, one at a time; a
//  record searches entries one at a time and then shifts entries back one at a time
//  to put the screen at the front. The single read port on the entry store sets this order.
//  Reset: synchronous, active low; empties the list, drops any held result, sets the
//  task mask to all ones and the default screen to zero.
//  Stalls: a held result does not block the next item; a finished one waits in FINISH.
//
module recent_screen_mru_list #(
    parameter int LIST_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item in
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rsml_pkg::KIND_W-1:0]     i_kind,
    input  logic [rsml_pkg::SCREEN_W-1:0]   i_screen,
    input  logic [rsml_pkg::POS_W-1:0]      i_position,
    // result out
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rsml_pkg::SCREEN_W-1:0]   o_screen_out,
    output logic                            o_hit,
    output logic [rsml_pkg::COUNT_W-1:0]    o_count,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [rsml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsml_pkg::CFG_W-1:0]      i_cfg_data
);

    rsml_pkg::t_cmd  cmd;
    rsml_pkg::t_stat stat;

    // Sequencer: walks each item through decode, search and shift steps
    rsml_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath: entry store, pointer, count, config and result register
    rsml_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_kind       (i_kind),
        .i_screen     (i_screen),
        .i_position   (i_position),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_screen_out (o_screen_out),
        .o_hit        (o_hit),
        .o_count      (o_count)
    );

endmodule
